>>> hw/rtl/lcd_pkg.sv
// Shared constants and types of the light change detector.
// Used by lcd_ring_ram and light_change_detector_top; no dependencies.
package lcd_pkg;

    // Sample width and the derived full-scale value.
    localparam int SAMPLE_BITS = 10;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] AVG_RESET  = FULL_SCALE >> 1;

    // Default depth of the sample ring.
    localparam int RING_DEPTH_DEF = 24;

    // Dead band register.
    localparam int BAND_BITS = 8;
    localparam logic [BAND_BITS-1:0] BAND_RESET = 8'd2;

    // Stream data widths (whole bytes).
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } t_lcd_state;

endpackage

>>> hw/rtl/lcd_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing but its parameters.
module lcd_serial_div #(
    parameter int DIVIDEND_W = 15,
    parameter int DIVISOR_W  = 5,
    parameter int QUOT_W     = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [QUOT_W-1:0]     o_quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dsr;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  n_rem;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[QUOT_W-1:0];

endmodule

>>> hw/rtl/lcd_ring_ram.sv
// Sample ring storage: one write port and one registered read port.
// Depends on lcd_pkg for the sample width.
module lcd_ring_ram
    import lcd_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]       i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [SAMPLE_BITS-1:0]       o_rd_data
);

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/light_change_detector_top.sv
// Light change detector: one result per sample, one sample in flight at a time.
// A sample outside the passband once the ring is full goes from ST_READ straight to
// ST_EMIT; a stored sample waits in ST_DIV for the bit-serial divider.
// A new sample is taken only back in ST_IDLE, once the last result has been emitted.
// Reset (i_rst_n low, synchronous) empties the ring, sets the average to mid-scale,
// the dead band to 2 and the declared level to low.
module light_change_detector_top
    import lcd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: dead band written whenever the enable is high.
    input  logic                 i_cfg_wr_en,
    input  logic [BAND_BITS-1:0] i_cfg_wr_data,
    // Input stream. tdata bits, lowest first: sample[9:0], zero padding.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Result stream. tdata bits, lowest first: level_high, level_changed,
    // accepted, average[9:0], zero padding.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Ring index, fill count (up to the depth itself) and sum widths.
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    // Sequencer.
    t_lcd_state r_state;
    t_lcd_state n_state;

    // Block state.
    logic [BAND_BITS-1:0]   r_band;
    logic [IDX_W-1:0]       r_wr_idx;
    logic                   r_full;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_avg;
    logic                   r_level;

    // Per-sample working registers.
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_accepted;

    // Output register.
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    // Combinational decisions.
    logic                   take_in;
    logic                   store;
    logic                   div_start;
    logic                   emit;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_quot;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] band_lo;
    logic [SAMPLE_BITS-1:0] band_hi;
    logic                   in_band;
    logic [SUM_W-1:0]       n_sum;
    logic [CNT_W-1:0]       divisor;
    logic [IDX_W-1:0]       n_wr_idx;
    logic                   idx_wrap;
    logic [SAMPLE_BITS:0]   avg_plus;
    logic [SAMPLE_BITS:0]   smp_plus;
    logic                   is_high;
    logic                   is_low;
    logic                   n_level;
    logic                   changed;

    // The sample store. The entry under the write pointer is read every cycle so
    // that the oldest sample is ready by the time the sequencer reaches ST_READ.
    lcd_ring_ram #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (store),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (r_sample),
        .i_rd_addr (r_wr_idx),
        .o_rd_data (rd_data)
    );

    // Shared divider: the fill count while filling, the ring depth once full.
    lcd_serial_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Passband around the stored average, and the ring update it leads to.
    always_comb begin
        band_lo  = r_avg - (r_avg >> 2);
        band_hi  = r_avg + ((FULL_SCALE - r_avg) >> 2);
        in_band  = (r_sample >= band_lo) && (r_sample <= band_hi);
        idx_wrap = (r_wr_idx == IDX_W'(RING_DEPTH - 1));
        n_wr_idx = idx_wrap ? '0 : r_wr_idx + 1'b1;
        if (r_full) begin
            n_sum   = r_sum - SUM_W'(rd_data) + SUM_W'(r_sample);
            divisor = CNT_W'(RING_DEPTH);
        end else begin
            n_sum   = r_sum + SUM_W'(r_sample);
            divisor = CNT_W'(r_wr_idx) + 1'b1;
        end
    end

    // Dead band comparison against the average after this sample.
    always_comb begin
        avg_plus = {1'b0, r_avg} + (SAMPLE_BITS + 1)'(r_band);
        smp_plus = {1'b0, r_sample} + (SAMPLE_BITS + 1)'(r_band);
        is_high  = ({1'b0, r_sample} > avg_plus);
        is_low   = (smp_plus < {1'b0, r_avg});
        priority if (is_high) begin
            n_level = 1'b1;
        end else if (is_low) begin
            n_level = 1'b0;
        end else begin
            n_level = r_level;
        end
        changed = (n_level != r_level);
    end

    // Next state and handshake decisions.
    always_comb begin
        n_state   = r_state;
        take_in   = 1'b0;
        store     = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                take_in = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                store     = !r_full || in_band;
                div_start = store;
                n_state   = store ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                emit = !r_out_valid || m_axis_tready;
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band      <= BAND_RESET;
            r_wr_idx    <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_avg       <= AVG_RESET;
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_band <= i_cfg_wr_data;
            end
            if (store) begin
                r_sum    <= n_sum;
                r_wr_idx <= n_wr_idx;
                if (idx_wrap) begin
                    r_full <= 1'b1;
                end
            end
            if (r_state == ST_DIV && div_done) begin
                r_avg <= div_quot;
            end
            if (emit) begin
                r_level     <= n_level;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample capture and result payload; these need no reset.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (r_state == ST_READ) begin
            r_accepted <= store;
        end
        if (emit) begin
            r_out_data <= M_TDATA_W'({r_avg, r_accepted, changed, n_level});
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
